### src/tfi_pkg.sv
// tfi_pkg: shared widths, channel count and controller/datapath bundles
// for the telemetry frame interpolator. No dependencies.
package tfi_pkg;

  localparam int unsigned TimeW    = 48;
  localparam int unsigned ChW      = 32;
  localparam int unsigned NumCh    = 11;
  localparam int unsigned PeriodW  = 10;
  localparam int unsigned MaxRun   = 64;
  localparam int unsigned RunW     = 7;   // holds 0..MaxRun
  localparam int unsigned DivW     = 48;  // dividend width of a divider lane
  localparam int unsigned DivCntW  = 6;   // counts DivW steps
  localparam int unsigned DataW    = 400; // time, position, nine channels

  // commands from the controller
  typedef struct packed {
    logic load;        // take the input word
    logic start_n;     // start gap / period
    logic start_step;  // start gap / n and channel diffs / n
    logic init_acc;    // seed the fill accumulators
    logic emit_fill;   // send one filler word
    logic emit_last;   // send the sample itself
  } tfi_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic gap_ok;      // previous sample exists and time moved forward
    logic div_busy;    // divider lanes running
    logic n_ge2;       // at least one filler word
    logic k_last;      // this filler word is the final one
    logic out_free;    // output register can take a word
  } tfi_sts_t;

endpackage

### src/tfi_div_lane.sv
// tfi_div_lane: bit-serial restoring divider, one quotient bit per cycle.
// Depends on tfi_pkg.
module tfi_div_lane
  import tfi_pkg::*;
(
  input  logic               clk_i,
  input  logic               start_i,
  input  logic               step_i,
  input  logic [DivW-1:0]    dividend_i,
  input  logic [PeriodW-1:0] divisor_i,
  output logic [DivW-1:0]    quot_o
);

  logic [DivW-1:0]    quo_q, quo_d;
  logic [PeriodW-1:0] rem_q, rem_d;
  logic [PeriodW-1:0] dvs_q;
  logic [PeriodW:0]   trial;
  logic               ge;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? PeriodW'(trial - {1'b0, dvs_q}) : trial[PeriodW-1:0];
    quo_d = {quo_q[DivW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = quo_q;

endmodule

### src/tfi_datapath.sv
// tfi_datapath: sample registers, divider lanes, fill accumulators and
// the output register. Depends on tfi_pkg and tfi_div_lane.
module tfi_datapath
  import tfi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PeriodW-1:0] period_i,
  input  logic [DataW-1:0]   in_data_i,
  input  tfi_cmd_t           cmd_i,
  output tfi_sts_t           sts_o,
  output logic               out_valid_o,
  output logic [DataW-1:0]   out_data_o,
  output logic               out_last_o,
  input  logic               out_ready_i
);

  logic [TimeW-1:0]   cur_t_q, prev_t_q, acc_t_q, tstep;
  logic [ChW-1:0]     cur_q [NumCh];
  logic [ChW-1:0]     prev_q [NumCh];
  logic [ChW-1:0]     acc_q [NumCh];
  logic [ChW-1:0]     step [NumCh];
  logic [NumCh-1:0]   neg_q;
  logic               have_prev_q;
  logic [RunW-1:0]    n_q, n_d, k_q;
  logic [DivCntW-1:0] cnt_q;
  logic [TimeW-1:0]   gap;
  logic [PeriodW-1:0] period_eff, lane_dvs;
  logic [DivW-1:0]    quot [NumCh+1];
  logic [ChW:0]       diff [NumCh];
  logic [ChW:0]       mag [NumCh];
  logic [DataW-1:0]   fill_word, last_word;
  logic [ChW-1:0]     fill_ch [NumCh];
  logic               out_valid_q, out_last_q;
  logic [DataW-1:0]   out_data_q;
  logic               step_en;

  assign gap        = cur_t_q - prev_t_q;
  assign period_eff = (period_i == '0) ? PeriodW'(1) : period_i;
  assign n_d        = (quot[0] >= DivW'(MaxRun)) ? RunW'(MaxRun) : quot[0][RunW-1:0];
  assign lane_dvs   = cmd_i.start_n ? period_eff : PeriodW'(n_d);
  assign step_en    = cnt_q != '0;
  assign tstep      = quot[0][TimeW-1:0];

  // time lane: first gap / period, then gap / n
  tfi_div_lane u_lane_t (
    .clk_i      (clk_i),
    .start_i    (cmd_i.start_n | cmd_i.start_step),
    .step_i     (step_en),
    .dividend_i (gap),
    .divisor_i  (lane_dvs),
    .quot_o     (quot[0])
  );

  // channel lanes divide the magnitude of the difference
  for (genvar i = 0; i < NumCh; i++) begin : g_ch
    assign diff[i] = {cur_q[i][ChW-1], cur_q[i]} - {prev_q[i][ChW-1], prev_q[i]};
    assign mag[i]  = diff[i][ChW] ? (ChW+1)'(-diff[i]) : diff[i];
    assign step[i] = neg_q[i] ? ChW'(-quot[i+1]) : quot[i+1][ChW-1:0];
    assign fill_ch[i] = acc_q[i] + step[i];

    tfi_div_lane u_lane (
      .clk_i      (clk_i),
      .start_i    (cmd_i.start_step),
      .step_i     (step_en),
      .dividend_i (DivW'(mag[i])),
      .divisor_i  (lane_dvs),
      .quot_o     (quot[i+1])
    );
  end

  // pack words: time, longitude, latitude, then the nine channels
  always_comb begin
    fill_word = '0;
    last_word = '0;
    fill_word[TimeW-1:0] = acc_t_q + tstep;
    last_word[TimeW-1:0] = cur_t_q;
    fill_word[TimeW +: ChW]     = fill_ch[1];
    fill_word[TimeW+ChW +: ChW] = fill_ch[0];
    last_word[TimeW +: ChW]     = cur_q[1];
    last_word[TimeW+ChW +: ChW] = cur_q[0];
    for (int i = 2; i < NumCh; i++) begin
      fill_word[TimeW + i*ChW +: ChW] = fill_ch[i];
      last_word[TimeW + i*ChW +: ChW] = cur_q[i];
    end
  end

  // sample, step and accumulator registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_t_q  <= in_data_i[TimeW-1:0];
      cur_q[0] <= in_data_i[TimeW+ChW +: ChW];
      cur_q[1] <= in_data_i[TimeW +: ChW];
      for (int i = 2; i < NumCh; i++) cur_q[i] <= in_data_i[TimeW + i*ChW +: ChW];
    end
    if (cmd_i.start_step) begin
      n_q <= n_d;
      for (int i = 0; i < NumCh; i++) neg_q[i] <= diff[i][ChW];
    end
    if (cmd_i.init_acc) begin
      acc_t_q <= prev_t_q;
      for (int i = 0; i < NumCh; i++) acc_q[i] <= prev_q[i];
      k_q <= RunW'(1);
    end else if (cmd_i.emit_fill) begin
      acc_t_q <= fill_word[TimeW-1:0];
      for (int i = 0; i < NumCh; i++) acc_q[i] <= fill_ch[i];
      k_q <= k_q + RunW'(1);
    end
    if (cmd_i.emit_last) begin
      prev_t_q <= cur_t_q;
      for (int i = 0; i < NumCh; i++) prev_q[i] <= cur_q[i];
    end
    if (cmd_i.emit_fill || cmd_i.emit_last) begin
      out_data_q <= cmd_i.emit_last ? last_word : fill_word;
      out_last_q <= cmd_i.emit_last;
    end
  end

  // control registers: step counter, history flag, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start_n || cmd_i.start_step) cnt_q <= DivCntW'(DivW - 1) + DivCntW'(1);
      else if (step_en) cnt_q <= cnt_q - DivCntW'(1);
      if (cmd_i.emit_last) have_prev_q <= 1'b1;
      if (cmd_i.emit_fill || cmd_i.emit_last) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.gap_ok   = have_prev_q && (cur_t_q > prev_t_q);
  assign sts_o.div_busy = step_en;
  assign sts_o.n_ge2    = n_d >= RunW'(2);
  assign sts_o.k_last   = k_q == (n_q - RunW'(1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

### src/tfi_ctrl.sv
// tfi_ctrl: sequencer for one sample: gap check, two divisions, filler
// words and the closing sample word. Depends on tfi_pkg.
module tfi_ctrl
  import tfi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tfi_sts_t sts_i,
  output tfi_cmd_t cmd_o,
  output logic     idle_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGap  = 3'd1;
  localparam logic [2:0] StDivN = 3'd2;
  localparam logic [2:0] StDivS = 3'd3;
  localparam logic [2:0] StFill = 3'd4;
  localparam logic [2:0] StLast = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StGap;
        end
      end
      StGap: begin
        if (sts_i.gap_ok) begin
          cmd_o.start_n = 1'b1;
          state_d       = StDivN;
        end else begin
          state_d = StLast;
        end
      end
      StDivN: begin
        if (!sts_i.div_busy) begin
          if (sts_i.n_ge2) begin
            cmd_o.start_step = 1'b1;
            state_d          = StDivS;
          end else begin
            state_d = StLast;
          end
        end
      end
      StDivS: begin
        if (!sts_i.div_busy) begin
          cmd_o.init_acc = 1'b1;
          state_d        = StFill;
        end
      end
      StFill: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fill = 1'b1;
          if (sts_i.k_last) state_d = StLast;
        end
      end
      StLast: begin
        if (sts_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  assign in_ready_o = state_q == StIdle;
  assign idle_o     = state_q == StIdle;

endmodule

### src/telemetry_frame_interpolator_core.sv
// channel     | dir | payload
// s_axis      | in  | tdata: sample_time, position, altitude .. lateral_g
// m_axis      | out | tdata: frame_time, frame_position, .. frame_lat_g; tlast: last
// cfg         | in  | cfg_wdata_i: frame_period
//
// One sample at a time: with no previous sample or no forward gap only the
// closing word; one 48-step division when the gap is under two periods; else
// gap / period, then gap and all channel differences / n in parallel lanes,
// then one word per cycle. Output stalls hold the sequencer.
// Reset clears the controller, history flag and output valid; period is 16.
// Depends on tfi_pkg, tfi_ctrl, tfi_datapath.
module telemetry_frame_interpolator_core
  import tfi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PeriodW-1:0] cfg_wdata_i,   // frame_period
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [47:0] sample_time, [111:48] position, then altitude, bearing, speed,
  // brake, steering, throttle, engine_rpm, yaw_rate, lateral_g (32 each)
  input  logic [DataW-1:0]   s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [47:0] frame_time, [111:48] frame_position, then frame_altitude,
  // frame_bearing, frame_speed, frame_brake, frame_steering,
  // frame_throttle, frame_rpm, frame_yaw, frame_lat_g (32 each)
  output logic [DataW-1:0]   m_axis_tdata,
  output logic               m_axis_tlast   // last
);

  logic [PeriodW-1:0] period_q;
  tfi_cmd_t           cmd;
  tfi_sts_t           sts;
  logic               idle;

  // period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       period_q <= PeriodW'(16);
    else if (cfg_we_i) period_q <= cfg_wdata_i;
  end

  tfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  tfi_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  // a taken sample blocks further input on the next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a sample is in work");

  // the closing word returns the controller to idle
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_last |=> idle)
    else $error("controller not idle after closing word");

  // never emit while the output register is held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_fill || cmd.emit_last) |-> sts.out_free)
    else $error("output word overwritten");

endmodule

### test/tb_telemetry_frame_interpolator_core.sv
// testbench for telemetry_frame_interpolator_core: drives samples, predicts
// interpolated filler words and the closing sample word, checks each word
// depends on tfi_pkg and the core rtl
module tb_telemetry_frame_interpolator_core
  import tfi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted or observed output word
  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
  } frame_word_t;

  // interpolation predictor and pending-word store
  class frame_scoreboard;
    frame_word_t        pending_q[$];
    logic [PeriodW-1:0] period;
    bit                 have_prev;
    logic [TimeW-1:0]   prev_time;
    longint             prev_ch[NumCh];
    int                 errors;
    int                 words_checked;
    int                 fills_seen;

    function new();
      period = 16;
      have_prev = 0;
      errors = 0;
      words_checked = 0;
      fills_seen = 0;
    endfunction

    function logic [DataW-1:0] pack_word(logic [TimeW-1:0] t, longint ch[NumCh]);
      logic [DataW-1:0] d;
      d = '0;
      d[TimeW-1:0] = t;
      d[TimeW+ChW-1 -: ChW] = ch[1][ChW-1:0];
      d[TimeW+2*ChW-1 -: ChW] = ch[0][ChW-1:0];
      for (int i = 2; i < NumCh; i++) d[TimeW+(i+1)*ChW-1 -: ChW] = ch[i][ChW-1:0];
      return d;
    endfunction

    // note an accepted sample and queue the words it should produce
    function void note_sample(logic [DataW-1:0] d);
      logic [TimeW-1:0] t;
      longint cur[NumCh];
      longint fill[NumCh];
      longint stp[NumCh];
      longint gap, per, n, tstep;
      frame_word_t w;
      t = d[TimeW-1:0];
      cur[0] = longint'(signed'(d[TimeW+2*ChW-1 -: ChW]));
      cur[1] = longint'(signed'(d[TimeW+ChW-1 -: ChW]));
      for (int i = 2; i < NumCh; i++)
        cur[i] = longint'(signed'(d[TimeW+(i+1)*ChW-1 -: ChW]));
      if (have_prev) begin
        gap = longint'({16'd0, t}) - longint'({16'd0, prev_time});
        if (gap > 0) begin
          per = (period == 0) ? 1 : longint'(period);
          n = gap / per;
          if (n > MaxRun) n = MaxRun;
          if (n > 0) begin
            tstep = gap / n;
            for (int i = 0; i < NumCh; i++) stp[i] = (cur[i] - prev_ch[i]) / n;
            for (longint k = 1; k < n; k++) begin
              for (int i = 0; i < NumCh; i++) fill[i] = prev_ch[i] + k * stp[i];
              w.data = pack_word(prev_time + TimeW'(k * tstep), fill);
              w.last = 1'b0;
              pending_q.push_back(w);
            end
          end
        end
      end
      w.data = pack_word(t, cur);
      w.last = 1'b1;
      pending_q.push_back(w);
      have_prev = 1;
      prev_time = t;
      prev_ch = cur;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare an accepted output word with the oldest prediction
    task check_word(logic [DataW-1:0] d, logic last);
      frame_word_t w;
      if (pending_q.size() == 0) begin
        report("unexpected output word");
        return;
      end
      w = pending_q.pop_front();
      words_checked++;
      if (!last) fills_seen++;
      if (d[TimeW-1:0] !== w.data[TimeW-1:0])
        report($sformatf("frame_time got %h exp %h", d[TimeW-1:0], w.data[TimeW-1:0]));
      if (d[TimeW+2*ChW-1:TimeW] !== w.data[TimeW+2*ChW-1:TimeW])
        report($sformatf("frame_position got %h exp %h",
               d[TimeW+2*ChW-1:TimeW], w.data[TimeW+2*ChW-1:TimeW]));
      for (int i = 2; i < NumCh; i++)
        if (d[TimeW+(i+1)*ChW-1 -: ChW] !== w.data[TimeW+(i+1)*ChW-1 -: ChW])
          report($sformatf("channel %0d got %h exp %h", i,
                 d[TimeW+(i+1)*ChW-1 -: ChW], w.data[TimeW+(i+1)*ChW-1 -: ChW]));
      if (last !== w.last) report($sformatf("last got %b exp %b", last, w.last));
    endtask
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we_i = 0;
  logic [PeriodW-1:0] cfg_wdata_i = '0;
  logic               s_axis_tvalid = 0;
  logic               s_axis_tready;
  logic [DataW-1:0]   s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 0;
  logic [DataW-1:0]   m_axis_tdata;
  logic               m_axis_tlast;

  frame_scoreboard sb = new();
  bit  quiet_mode = 0;
  int  idle_cycles = 0;
  int  samples_sent = 0;
  logic [TimeW-1:0] clock_ms = '0;

  localparam int WatchdogLimit = 20000;

  always #10 clk_i = ~clk_i;

  telemetry_frame_interpolator_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  // output side: random stall bursts, check words at the accepting edge
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
      if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d words pending", sb.pending_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function logic [DataW-1:0] rand_channels(logic [TimeW-1:0] t, int mode);
    logic [DataW-1:0] d;
    d = '0;
    d[TimeW-1:0] = t;
    for (int i = 0; i < NumCh; i++) begin
      logic [ChW-1:0] v;
      case (mode)
        0: v = $urandom;
        1: v = 32'h7fff_ffff;
        2: v = 32'h8000_0000;
        default: v = $urandom_range(0, 2000) - 1000;
      endcase
      d[TimeW+(i+1)*ChW-1 -: ChW] = v;
    end
    return d;
  endfunction

  // send one sample, right after the last one or after a random gap
  task send_sample(logic [DataW-1:0] d);
    int wait_cycles;
    wait_cycles = (!quiet_mode && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 1;
    repeat (wait_cycles) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(d);
    samples_sent++;
    s_axis_tvalid <= 1'b0;
  endtask

  task wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task write_period(logic [PeriodW-1:0] p);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.period = p;
  endtask

  // timestamp advance: mostly one to twelve periods, sometimes short, long or backward
  task random_sample(int mode);
    int per;
    int sel;
    per = (sb.period == 0) ? 1 : sb.period;
    sel = $urandom_range(0, 9);
    if (sel == 0) clock_ms = clock_ms - $urandom_range(0, 50);
    else if (sel == 1) clock_ms = clock_ms + $urandom_range(0, per - 1);
    else if (sel == 2) clock_ms = clock_ms + per * $urandom_range(60, 200);
    else clock_ms = clock_ms + $urandom_range(per, per * 12);
    send_sample(rand_channels(clock_ms, mode));
  endtask

  initial begin
    logic [PeriodW-1:0] periods[6];
    periods = '{10'd1, 10'd1000, 10'd0, 10'd7, 10'd16, 10'd3};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first sample, extremes, equal and backward time, long gap
    clock_ms = 1000;
    send_sample(rand_channels(clock_ms, 2));
    clock_ms += 16 * 5;
    send_sample(rand_channels(clock_ms, 1));
    clock_ms += 16 * 5;
    send_sample(rand_channels(clock_ms, 2));
    send_sample(rand_channels(clock_ms, 0));
    clock_ms -= 40;
    send_sample(rand_channels(clock_ms, 0));
    clock_ms += 10;
    send_sample(rand_channels(clock_ms, 3));
    clock_ms += 16 * 100;
    send_sample(rand_channels(clock_ms, 0));
    clock_ms += 33;
    send_sample(rand_channels(clock_ms, 3));
    clock_ms = 48'hffff_ffff_ff00;
    send_sample(rand_channels(clock_ms, 0));
    clock_ms = 48'hffff_ffff_ffff;
    send_sample(rand_channels(clock_ms, 1));
    clock_ms = 0;
    send_sample(rand_channels(clock_ms, 0));
    clock_ms = 48'h5555_aaaa_5555;
    send_sample(rand_channels(clock_ms, 0));

    // random phases across several periods
    for (int ph = 0; ph < 6; ph++) begin
      write_period(periods[ph]);
      if (ph == 5) quiet_mode = 1;
      for (int i = 0; i < 32; i++) random_sample($urandom_range(0, 4) == 0 ? 3 : 0);
    end

    wait_drained();
    $display("covered %0d samples, %0d words checked, %0d filler words, six periods",
             samples_sent, sb.words_checked, sb.fills_seen);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

### filelist.f
src/tfi_pkg.sv
src/tfi_div_lane.sv
src/tfi_datapath.sv
src/tfi_ctrl.sv
src/telemetry_frame_interpolator_core.sv
test/tb_telemetry_frame_interpolator_core.sv
